[rtl/aglm_pkg.sv]
`default_nettype none
package aglm_pkg;

	localparam int SUM_W      = 50;
	localparam int AVG_W      = 40;
	localparam int CNT_W      = 11;
	localparam int COEFF_W    = 24;
	localparam int GAIN_W     = 19;
	localparam int RATIO_FRAC = 32;
	localparam int QUO_W      = AVG_W + RATIO_FRAC;
	localparam int REM_W      = AVG_W + 1;
	localparam int ALU_W      = 65;
	localparam int ACC_W      = AVG_W + COEFF_W;
	localparam int SQRT_ITER  = 18;
	localparam int ITER_W     = 7;

	localparam logic [GAIN_W-1:0]  GAIN_MIN    = 19'd16384;
	localparam logic [GAIN_W-1:0]  GAIN_MAX    = 19'd262144;
	localparam logic [GAIN_W-1:0]  GAIN_UNITY  = 19'd65536;
	localparam logic [COEFF_W-1:0] COEFF_RESET = 24'd7454;

	typedef enum logic {
		REG_ENABLE = 1'b0,
		REG_COEFF  = 1'b1
	} reg_idx_t;

endpackage
`default_nettype wire

[rtl/auto_gain_level_matcher.sv]
`default_nettype none
// Automatic gain level matcher.
// Input stream (s_*): one word per block of audio samples, carrying the summed
// input energy, summed processed energy and sample count. s_tready is high only
// while the block is idle; one word is taken and worked to the end before the
// next is accepted.
// Output stream (m_*): exactly one word per input word, holding the makeup gain
// target (Q3.16) and a flag in m_tuser that marks it valid. The result sits in
// an output register; the block may accept the next input word while it waits.
// A word that reaches the square root runs two 50-step means, two 24-step
// average updates with an extra negate step for each falling average, a 72-step
// ratio division, an 18-step square root, two compare steps and a rounding
// step, all run through one shared 65-bit add/subtract unit. A zero count goes
// straight to the final state; silent words skip the average updates, and
// disabled or clamped words finish before the division. Once the result is
// loaded the sequencer returns to idle and can take the next word.
// A stalled receiver holds the result in place; the sequencer may work the
// next word but then waits in its final state until the held word is taken.
// Reset clears both averages, disables auto gain and loads the default
// averaging coefficient. The APB port is always ready and may be written while
// the block is idle.
module auto_gain_level_matcher #(
	parameter int MAX_SAMPLES      = 1024,
	parameter int ENERGY_FRAC_BITS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// input_energy_sum[49:0], processed_energy_sum[99:50], sample_count[110:100]
	input  wire logic [111:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// makeup_target[18:0]
	output logic [23:0]       m_tdata,
	// target_valid[0]
	output logic [0:0]        m_tuser,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int SW = aglm_pkg::SUM_W;
	localparam int AW = aglm_pkg::AVG_W;
	localparam int CW = aglm_pkg::CNT_W;
	localparam int KW = aglm_pkg::COEFF_W;
	localparam int GW = aglm_pkg::GAIN_W;
	localparam int QW = aglm_pkg::QUO_W;
	localparam int RW = aglm_pkg::REM_W;
	localparam int LW = aglm_pkg::ALU_W;
	localparam int MW = aglm_pkg::ACC_W;
	localparam int IW = aglm_pkg::ITER_W;
	localparam int SI = aglm_pkg::SQRT_ITER;

	localparam int CountCapInt = (MAX_SAMPLES > (2 ** CW) - 1) ? (2 ** CW) - 1 : MAX_SAMPLES;
	localparam logic [CW-1:0] CountCap = CW'(CountCapInt);
	localparam logic [63:0] Floor64 =
		((64'd1 << ENERGY_FRAC_BITS) + 64'd500000000) / 64'd1000000000;
	localparam logic [AW-1:0] Floor = Floor64[AW-1:0];
	localparam logic [IW-1:0] MeanIter = IW'(SW - 1);
	localparam logic [IW-1:0] MulIter  = IW'(KW - 1);
	localparam logic [IW-1:0] DivIter  = IW'(QW - 1);
	localparam logic [IW-1:0] SqrtIter = IW'(SI - 1);
	localparam logic [MW-1:0] RoundHalf = MW'(1) << (KW - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MDIV,
		ST_CHECK,
		ST_DIFF,
		ST_NEG,
		ST_MUL,
		ST_APPLY,
		ST_GATE,
		ST_CMPH,
		ST_CMPL,
		ST_GDIV,
		ST_SQRT,
		ST_RND,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic                ch_q;
	logic [AW-1:0]       avg_in_q;
	logic [AW-1:0]       avg_pr_q;
	logic                m_tvalid_q;
	logic [GW-1:0]       m_target_q;
	logic                m_flag_q;
	logic                enable_q;
	logic [KW-1:0]       coeff_q;

	logic [SW-1:0]       sum_pr_q;
	logic [AW-1:0]       den_q;
	logic [QW-1:0]       quo_q;
	logic [RW-1:0]       rem_q;
	logic [IW-1:0]       cnt_q;
	logic [AW-1:0]       mean_in_q;
	logic [AW-1:0]       mean_pr_q;
	logic                up_q;
	logic [MW-1:0]       acc_q;
	logic [MW-1:0]       mcand_q;
	logic [KW-1:0]       mult_q;
	logic [GW-1:0]       root_q;
	logic                res_flag_q;
	logic [GW-1:0]       res_target_q;

	logic [LW-1:0]       alu_a;
	logic [LW-1:0]       alu_b;
	logic                alu_sub;
	logic [LW:0]         alu_full;
	logic [LW-1:0]       alu_res;
	logic                alu_carry;

	logic [SW-1:0]       sum_in;
	logic [SW-1:0]       sum_pr;
	logic [CW-1:0]       count_in;
	logic [CW-1:0]       count_clamped;
	logic [AW-1:0]       mean_sel;
	logic [AW-1:0]       avg_sel;
	logic [QW-1:0]       q_next;
	logic [RW-1:0]       r_next;
	logic [AW-1:0]       mean_sat;
	logic [GW-1:0]       gain_rnd;
	logic [GW-1:0]       gain_clamped;
	logic                gate_fail;
	logic                cfg_write;

	assign sum_in        = s_tdata[SW-1:0];
	assign sum_pr        = s_tdata[2*SW-1:SW];
	assign count_in      = s_tdata[2*SW+CW-1:2*SW];
	assign count_clamped = (count_in > CountCap) ? CountCap : count_in;

	assign mean_sel = ch_q ? mean_pr_q : mean_in_q;
	assign avg_sel  = ch_q ? avg_pr_q : avg_in_q;

	// shared add/subtract unit
	assign alu_full  = {1'b0, alu_a} + {1'b0, alu_b ^ {LW{alu_sub}}} + (LW + 1)'(alu_sub);
	assign alu_res   = alu_full[LW-1:0];
	assign alu_carry = alu_full[LW];

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b1;
		unique case (state_q)
			ST_MDIV, ST_GDIV: begin
				alu_a = LW'({rem_q, quo_q[QW-1]});
				alu_b = LW'(den_q);
			end
			ST_DIFF: begin
				alu_a = LW'(mean_sel);
				alu_b = LW'(avg_sel);
			end
			ST_NEG: begin
				alu_a = LW'(avg_sel);
				alu_b = LW'(mean_sel);
			end
			ST_MUL: begin
				alu_a   = LW'(acc_q);
				alu_b   = LW'(mcand_q);
				alu_sub = 1'b0;
			end
			ST_APPLY: begin
				alu_a   = LW'(avg_sel);
				alu_b   = LW'(acc_q[MW-1:KW]);
				alu_sub = !up_q;
			end
			ST_CMPH: begin
				alu_a = LW'(avg_in_q);
				alu_b = LW'({avg_pr_q, 4'b0000});
			end
			ST_CMPL: begin
				alu_a = LW'(avg_pr_q);
				alu_b = LW'({avg_in_q, 4'b0000});
			end
			ST_SQRT: begin
				alu_a = LW'({rem_q[GW-1:0], quo_q[2*SI-1 -: 2]});
				alu_b = LW'({root_q, 2'b01});
			end
			ST_RND: begin
				alu_a = LW'(root_q);
				alu_b = LW'(rem_q);
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b1;
			end
		endcase
	end

	assign q_next   = {quo_q[QW-2:0], alu_carry};
	assign r_next   = alu_carry ? alu_res[RW-1:0] : {rem_q[RW-2:0], quo_q[QW-1]};
	assign mean_sat = (|q_next[SW-1:AW]) ? {AW{1'b1}} : q_next[AW-1:0];

	assign gain_rnd     = alu_carry ? root_q : root_q + GW'(1);
	assign gain_clamped = (gain_rnd < aglm_pkg::GAIN_MIN) ? aglm_pkg::GAIN_MIN :
		(gain_rnd > aglm_pkg::GAIN_MAX) ? aglm_pkg::GAIN_MAX : gain_rnd;

	assign gate_fail = !enable_q || (avg_in_q <= Floor) || (avg_pr_q <= Floor);

	// sequencer, averages and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ch_q       <= 1'b0;
			avg_in_q   <= '0;
			avg_pr_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_target_q <= aglm_pkg::GAIN_UNITY;
			m_flag_q   <= 1'b0;
		end else begin
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ch_q    <= 1'b0;
						state_q <= (count_in == '0) ? ST_DONE : ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (cnt_q == '0) begin
						if (!ch_q) begin
							ch_q <= 1'b1;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (mean_in_q > Floor && mean_pr_q > Floor) begin
						ch_q    <= 1'b0;
						state_q <= ST_DIFF;
					end else begin
						state_q <= ST_GATE;
					end
				end
				ST_DIFF: begin
					state_q <= alu_carry ? ST_MUL : ST_NEG;
				end
				ST_NEG: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (!ch_q) begin
						avg_in_q <= alu_res[AW-1:0];
						ch_q     <= 1'b1;
						state_q  <= ST_DIFF;
					end else begin
						avg_pr_q <= alu_res[AW-1:0];
						state_q  <= ST_GATE;
					end
				end
				ST_GATE: begin
					state_q <= gate_fail ? ST_DONE : ST_CMPH;
				end
				ST_CMPH: begin
					state_q <= alu_carry ? ST_DONE : ST_CMPL;
				end
				ST_CMPL: begin
					state_q <= alu_carry ? ST_DONE : ST_GDIV;
				end
				ST_GDIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_target_q <= res_target_q;
						m_flag_q   <= res_flag_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					quo_q        <= {sum_in, (QW - SW)'(0)};
					rem_q        <= '0;
					den_q        <= AW'(count_clamped);
					sum_pr_q     <= sum_pr;
					cnt_q        <= MeanIter;
					res_flag_q   <= 1'b0;
					res_target_q <= aglm_pkg::GAIN_UNITY;
				end
			end
			ST_MDIV: begin
				if (cnt_q == '0 && !ch_q) begin
					mean_in_q <= mean_sat;
					quo_q     <= {sum_pr_q, (QW - SW)'(0)};
					rem_q     <= '0;
					cnt_q     <= MeanIter;
				end else begin
					quo_q <= q_next;
					rem_q <= r_next;
					cnt_q <= cnt_q - IW'(1);
					if (cnt_q == '0) begin
						mean_pr_q <= mean_sat;
					end
				end
			end
			ST_DIFF, ST_NEG: begin
				if (state_q == ST_NEG || alu_carry) begin
					up_q    <= (state_q == ST_DIFF);
					mcand_q <= MW'(alu_res[AW-1:0]);
					acc_q   <= RoundHalf;
					mult_q  <= coeff_q;
					cnt_q   <= MulIter;
				end
			end
			ST_MUL: begin
				if (mult_q[0]) begin
					acc_q <= alu_res[MW-1:0];
				end
				mcand_q <= {mcand_q[MW-2:0], 1'b0};
				mult_q  <= {1'b0, mult_q[KW-1:1]};
				cnt_q   <= cnt_q - IW'(1);
			end
			ST_GATE: begin
				res_flag_q   <= 1'b0;
				res_target_q <= aglm_pkg::GAIN_UNITY;
			end
			ST_CMPH: begin
				if (alu_carry) begin
					res_flag_q   <= 1'b1;
					res_target_q <= aglm_pkg::GAIN_MAX;
				end
			end
			ST_CMPL: begin
				if (alu_carry) begin
					res_flag_q   <= 1'b1;
					res_target_q <= aglm_pkg::GAIN_MIN;
				end else begin
					quo_q <= {avg_in_q, (QW - AW)'(0)};
					rem_q <= '0;
					den_q <= avg_pr_q;
					cnt_q <= DivIter;
				end
			end
			ST_GDIV: begin
				quo_q <= q_next;
				if (cnt_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= SqrtIter;
				end else begin
					rem_q <= r_next;
					cnt_q <= cnt_q - IW'(1);
				end
			end
			ST_SQRT: begin
				quo_q <= {quo_q[QW-3:0], 2'b00};
				cnt_q <= cnt_q - IW'(1);
				if (alu_carry) begin
					rem_q  <= alu_res[RW-1:0];
					root_q <= {root_q[GW-2:0], 1'b1};
				end else begin
					rem_q  <= {rem_q[RW-3:0], quo_q[2*SI-1 -: 2]};
					root_q <= {root_q[GW-2:0], 1'b0};
				end
			end
			ST_RND: begin
				res_flag_q   <= 1'b1;
				res_target_q <= gain_clamped;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			coeff_q  <= aglm_pkg::COEFF_RESET;
		end else if (cfg_write) begin
			unique case (aglm_pkg::reg_idx_t'(paddr[2]))
				aglm_pkg::REG_ENABLE: enable_q <= pwdata[0];
				aglm_pkg::REG_COEFF:  coeff_q  <= pwdata[KW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (aglm_pkg::reg_idx_t'(paddr[2]))
			aglm_pkg::REG_ENABLE: prdata = {31'b0, enable_q};
			aglm_pkg::REG_COEFF:  prdata = {(32 - KW)'(0), coeff_q};
			default:              prdata = '0;
		endcase
	end

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(24 - GW)'(0), m_target_q};
	assign m_tuser  = m_flag_q;

endmodule
`default_nettype wire

[rtl/aglm_checker.sv]
`default_nettype none
module aglm_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [23:0]  m_tdata,
	input wire logic [0:0]   m_tuser
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// not ready for new input after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	a_unity_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[18:0] == aglm_pkg::GAIN_UNITY)
		else $error("invalid target not unity");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |->
			m_tdata[18:0] >= aglm_pkg::GAIN_MIN && m_tdata[18:0] <= aglm_pkg::GAIN_MAX)
		else $error("target outside gain range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[23:19] == 5'd0)
		else $error("result padding not zero");

endmodule

bind auto_gain_level_matcher aglm_checker u_aglm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
